// File: rtl/u32sr_pkg.sv
package u32sr_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned UNIT_W    = 16;
   localparam int unsigned CP_W      = 32;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned CHARS_W   = 16;
   localparam int unsigned BYTES_W   = 18;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [CP_W-1:0]    UNI_MAX    = 32'h0010_FFFF;
   localparam logic [CP_W-1:0]    BMP_TOP    = 32'h0000_FFFF;
   localparam logic [20:0]        BMP_SPAN   = 21'h01_0000;
   localparam logic [UNIT_W-1:0]  REPL_UNIT  = 16'hFFFD;
   localparam logic [UNIT_W-1:0]  SURR_HI    = 16'hD800;
   localparam logic [UNIT_W-1:0]  SURR_LO    = 16'hDC00;
   localparam logic [COUNT_W-1:0] POINT_MAX  = 16'hFFFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LITTLE_ENDIAN  = 3'd0,
      CSR_USE_TERMINATOR = 3'd1,
      CSR_USE_BYTE_LIMIT = 3'd2,
      CSR_USE_CHAR_LIMIT = 3'd3,
      CSR_TERMINATOR     = 3'd4,
      CSR_MAX_CHARS      = 3'd5,
      CSR_MAX_BYTES      = 3'd6,
      CSR_SKIP_INVALID   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_TERM     = 3'd1,
      CAUSE_BYTES    = 3'd2,
      CAUSE_CHARS    = 3'd3,
      CAUSE_DATA_OUT = 3'd4,
      CAUSE_EMPTY    = 3'd5
   } cause_type;

   typedef enum logic [1:0] {
      KIND_END  = 2'd0,
      KIND_ONE  = 2'd1,
      KIND_PAIR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [UNIT_W-1:0]    unit_hi;
      logic [UNIT_W-1:0]    unit_lo;
      logic [CP_W-1:0]      cp;
      logic                 last;
      cause_type            cause;
      logic                 nodata;
      logic [COUNT_W-1:0]   points;
   } entry_type;

endpackage

// File: rtl/utf32_string_reader.sv
// Channel  Direction  Word
// req_     in         tdata: byte_value[7:0]; tuser: start_flag; tlast: end_of_data
// rsp_     out        tdata: utf16_unit, code_point, end_cause, no_data_at_start,
//                     points_read; tuser: unit_present; tlast: last
// csr_     in         write enable, register index, 32-bit write data
//
// One byte word is taken per cycle while the queue has room; results leave one per cycle
// from the single output register while rsp_tready holds, a surrogate pair as two words.
// The queue between byte decode and unit emit holds QUEUE_DEPTH decoded points;
// req_tready drops only when it is full.
// Synchronous reset restores the control registers to their defaults and empties the queue.
module utf32_string_reader #(
   parameter int unsigned QUEUE_DEPTH = u32sr_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [u32sr_pkg::BYTE_W-1:0]         req_tdata,   // byte_value
   input  logic                                 req_tuser,   // start_flag
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // utf16_unit[15:0], code_point[47:16], end_cause[50:48], no_data_at_start[51],
   // points_read[67:52], zero fill
   output logic [u32sr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,   // unit_present
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [u32sr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [u32sr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                   push;
   logic                   pop;
   logic                   full;
   logic                   empty;
   u32sr_pkg::entry_type   push_entry;
   u32sr_pkg::entry_type   head;

   u32sr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   u32sr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   u32sr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/u32sr_front.sv
module u32sr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [u32sr_pkg::BYTE_W-1:0]         req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   input  logic                                 csr_we,
   input  logic [u32sr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [u32sr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 queue_full,
   output logic                                 push,
   output u32sr_pkg::entry_type                 push_entry
);

   logic                                 little_endian_ff;
   logic                                 use_term_ff;
   logic                                 use_bytes_ff;
   logic                                 use_chars_ff;
   logic [u32sr_pkg::CP_W-1:0]           term_ff;
   logic [u32sr_pkg::CHARS_W-1:0]        max_chars_ff;
   logic [u32sr_pkg::BYTES_W-1:0]        max_bytes_ff;
   logic                                 skip_ff;

   logic [23:0]                          buf_ff, buf_in, buf_eff;
   logic [1:0]                           phase_ff, phase_in, phase_eff;
   logic [u32sr_pkg::COUNT_W-1:0]        pc_ff, pc_in, pc_eff, pc_new;
   logic                                 done_ff, done_in, done_eff;

   logic                                 accept;
   logic                                 zero_limit;
   logic                                 push_c;
   logic [u32sr_pkg::CP_W-1:0]           cp;
   logic [19:0]                          cp_off;
   u32sr_pkg::cause_type                 cause;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && push_c;

   assign zero_limit = (use_chars_ff && (max_chars_ff == '0))
                    || (use_bytes_ff && (max_bytes_ff < u32sr_pkg::BYTES_W'(2)));

   assign cp = little_endian_ff ? {req_tdata, buf_ff[7:0], buf_ff[15:8], buf_ff[23:16]}
                                : {buf_ff, req_tdata};
   assign cp_off = 20'(cp[20:0] - u32sr_pkg::BMP_SPAN);

   always_comb begin
      buf_eff   = req_tuser ? '0 : buf_ff;
      phase_eff = req_tuser ? '0 : phase_ff;
      pc_eff    = req_tuser ? '0 : pc_ff;
      done_eff  = req_tuser ? 1'b0 : done_ff;
      pc_new    = (pc_eff == u32sr_pkg::POINT_MAX) ? pc_eff : pc_eff + 1'b1;

      if (use_term_ff && (cp == term_ff)) begin
         cause = u32sr_pkg::CAUSE_TERM;
      end else if (use_bytes_ff && (pc_new >= max_bytes_ff[u32sr_pkg::BYTES_W-1:2])) begin
         cause = u32sr_pkg::CAUSE_BYTES;
      end else if (use_chars_ff && (pc_new >= max_chars_ff)) begin
         cause = u32sr_pkg::CAUSE_CHARS;
      end else if (req_tlast) begin
         cause = u32sr_pkg::CAUSE_DATA_OUT;
      end else begin
         cause = u32sr_pkg::CAUSE_NONE;
      end

      buf_in   = buf_eff;
      phase_in = phase_eff;
      pc_in    = pc_eff;
      done_in  = done_eff;
      push_c   = 1'b0;
      push_entry.kind    = u32sr_pkg::KIND_END;
      push_entry.unit_hi = '0;
      push_entry.unit_lo = '0;
      push_entry.cp      = '0;
      push_entry.last    = 1'b1;
      push_entry.cause   = u32sr_pkg::CAUSE_NONE;
      push_entry.nodata  = 1'b0;
      push_entry.points  = pc_eff;

      if (req_tuser && zero_limit) begin
         done_in = 1'b1;
         push_c  = 1'b1;
         push_entry.cause = u32sr_pkg::CAUSE_EMPTY;
      end else if (done_eff) begin
         push_c = 1'b0;
      end else if (phase_eff != 2'd3) begin
         buf_in   = {buf_eff[15:0], req_tdata};
         phase_in = phase_eff + 2'd1;
         if (req_tlast) begin
            done_in  = 1'b1;
            buf_in   = '0;
            phase_in = '0;
            push_c   = 1'b1;
            push_entry.cause  = u32sr_pkg::CAUSE_DATA_OUT;
            push_entry.nodata = (pc_eff == '0);
         end
      end else begin
         buf_in   = '0;
         phase_in = '0;
         pc_in    = pc_new;
         done_in  = (cause != u32sr_pkg::CAUSE_NONE);
         push_entry.points = pc_new;
         push_entry.cause  = cause;
         if (cp > u32sr_pkg::UNI_MAX) begin
            if (skip_ff) begin
               push_c = (cause != u32sr_pkg::CAUSE_NONE);
            end else begin
               push_c = 1'b1;
               push_entry.kind    = u32sr_pkg::KIND_ONE;
               push_entry.unit_lo = u32sr_pkg::REPL_UNIT;
               push_entry.cp      = cp;
               push_entry.last    = (cause != u32sr_pkg::CAUSE_NONE);
            end
         end else if (cp > u32sr_pkg::BMP_TOP) begin
            push_c = 1'b1;
            push_entry.kind    = u32sr_pkg::KIND_PAIR;
            push_entry.unit_hi = u32sr_pkg::SURR_HI | {6'd0, cp_off[19:10]};
            push_entry.unit_lo = u32sr_pkg::SURR_LO | {6'd0, cp_off[9:0]};
            push_entry.cp      = cp;
            push_entry.last    = (cause != u32sr_pkg::CAUSE_NONE);
         end else begin
            push_c = 1'b1;
            push_entry.kind    = u32sr_pkg::KIND_ONE;
            push_entry.unit_lo = cp[u32sr_pkg::UNIT_W-1:0];
            push_entry.cp      = cp;
            push_entry.last    = (cause != u32sr_pkg::CAUSE_NONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b1;
         use_term_ff      <= 1'b1;
         use_bytes_ff     <= 1'b0;
         use_chars_ff     <= 1'b0;
         term_ff          <= '0;
         max_chars_ff     <= '0;
         max_bytes_ff     <= '0;
         skip_ff          <= 1'b0;
         buf_ff           <= '0;
         phase_ff         <= '0;
         pc_ff            <= '0;
         done_ff          <= 1'b1;
      end else begin
         if (csr_we) begin
            case (u32sr_pkg::csr_index_type'(csr_addr))
               u32sr_pkg::CSR_LITTLE_ENDIAN:  little_endian_ff <= csr_wdata[0];
               u32sr_pkg::CSR_USE_TERMINATOR: use_term_ff      <= csr_wdata[0];
               u32sr_pkg::CSR_USE_BYTE_LIMIT: use_bytes_ff     <= csr_wdata[0];
               u32sr_pkg::CSR_USE_CHAR_LIMIT: use_chars_ff     <= csr_wdata[0];
               u32sr_pkg::CSR_TERMINATOR:     term_ff          <= csr_wdata;
               u32sr_pkg::CSR_MAX_CHARS:
                  max_chars_ff <= csr_wdata[u32sr_pkg::CHARS_W-1:0];
               u32sr_pkg::CSR_MAX_BYTES:
                  max_bytes_ff <= csr_wdata[u32sr_pkg::BYTES_W-1:0];
               u32sr_pkg::CSR_SKIP_INVALID:   skip_ff          <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            buf_ff   <= buf_in;
            phase_ff <= phase_in;
            pc_ff    <= pc_in;
            done_ff  <= done_in;
         end
      end
   end

endmodule

// File: rtl/u32sr_queue.sv
module u32sr_queue #(
   parameter int unsigned DEPTH = u32sr_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u32sr_pkg::entry_type  push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output u32sr_pkg::entry_type  head
);

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   u32sr_pkg::entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/u32sr_back.sv
module u32sr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  u32sr_pkg::entry_type                 head,
   input  logic                                 empty,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [u32sr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   logic                                 valid_ff, valid_in;
   logic                                 half_ff, half_in;
   logic [u32sr_pkg::RSP_DATA_W-1:0]     data_ff, data_in;
   logic                                 user_ff, user_in;
   logic                                 last_ff, last_in;
   logic                                 load;
   logic                                 take;
   logic                                 first_half;
   logic [u32sr_pkg::UNIT_W-1:0]         unit;
   u32sr_pkg::cause_type                 cause;

   assign load       = !valid_ff || rsp_tready;
   assign take       = load && !empty;
   assign first_half = (head.kind == u32sr_pkg::KIND_PAIR) && !half_ff;
   assign pop        = take && !first_half;

   always_comb begin
      case (head.kind)
         u32sr_pkg::KIND_PAIR: begin
            unit    = half_ff ? head.unit_lo : head.unit_hi;
            user_in = 1'b1;
         end
         u32sr_pkg::KIND_ONE: begin
            unit    = head.unit_lo;
            user_in = 1'b1;
         end
         default: begin
            unit    = '0;
            user_in = 1'b0;
         end
      endcase
      last_in  = first_half ? 1'b0 : head.last;
      cause    = first_half ? u32sr_pkg::CAUSE_NONE : head.cause;
      data_in  = {4'd0, head.points, head.nodata, cause, head.cp, unit};
      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
      half_in  = take ? first_half : half_ff;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/u32sr_checker.sv
module u32sr_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [u32sr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 rsp_tuser,
   input  logic                                 rsp_tlast
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[47:0] == '0))
      else $error("end-only word not last or carries a unit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_tdata[50:48] == u32sr_pkg::CAUSE_NONE) && !rsp_tdata[51])
      else $error("end status on a word that is not last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[51] |->
         (rsp_tdata[50:48] == u32sr_pkg::CAUSE_DATA_OUT) && (rsp_tdata[67:52] == '0))
      else $error("no-data flag without data-ran-out status");

endmodule

bind utf32_string_reader u32sr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
